// ===== hdl/mmbd_pkg.sv =====
`timescale 1ns / 1ps

package mmbd_pkg;

	// Target codes of the forwarded regions.
	localparam logic [2:0] TGT_LOCAL  = 3'd0;
	localparam logic [2:0] TGT_ROM    = 3'd1;
	localparam logic [2:0] TGT_VRAM   = 3'd2;
	localparam logic [2:0] TGT_CRAM   = 3'd3;
	localparam logic [2:0] TGT_OAM    = 3'd4;
	localparam logic [2:0] TGT_JOYPAD = 3'd5;
	localparam logic [2:0] TGT_TIMER  = 3'd6;
	localparam logic [2:0] TGT_VIDEO  = 3'd7;

	// Read value of an unmapped address and the unwired interrupt bits.
	localparam logic [7:0] RD_UNMAPPED = 8'hFF;
	localparam logic [7:0] IRQ_PAD     = 8'hE0;

	// Local storage that an access selects.
	typedef enum logic [2:0] {
		LK_NONE,
		LK_WRAM,
		LK_HRAM,
		LK_IFLAG,
		LK_IENABLE,
		LK_BOOT
	} local_kind_t;

	// Decode of one bus address.
	typedef struct packed {
		logic [2:0]  target;
		local_kind_t kind;
		logic        hole;
	} dec_t;

endpackage

// ===== hdl/mmbd_decode.sv =====
`timescale 1ns / 1ps

module mmbd_decode (
	input  logic [15:0]   addr,
	output mmbd_pkg::dec_t dec
);
	import mmbd_pkg::*;

	// Forwarded regions first; everything else is local or unmapped.
	always_comb begin
		dec.target = TGT_LOCAL;
		dec.kind   = LK_NONE;
		dec.hole   = 1'b0;
		if (addr inside {[16'h0000:16'h7FFF]}) begin
			dec.target = TGT_ROM;
		end else if (addr inside {[16'h8000:16'h9FFF]}) begin
			dec.target = TGT_VRAM;
		end else if (addr inside {[16'hA000:16'hBFFF]}) begin
			dec.target = TGT_CRAM;
		end else if (addr inside {[16'hFE00:16'hFE9F]}) begin
			dec.target = TGT_OAM;
		end else if (addr == 16'hFF00) begin
			dec.target = TGT_JOYPAD;
		end else if (addr inside {[16'hFF04:16'hFF07]}) begin
			dec.target = TGT_TIMER;
		end else if (addr inside {[16'hFF40:16'hFF49]}) begin
			dec.target = TGT_VIDEO;
		end else if (addr inside {[16'hC000:16'hDFFF]}) begin
			dec.kind = LK_WRAM;
		end else if (addr == 16'hFF0F) begin
			dec.kind = LK_IFLAG;
		end else if (addr == 16'hFF50) begin
			dec.kind = LK_BOOT;
		end else if (addr inside {[16'hFF80:16'hFFFE]}) begin
			dec.kind = LK_HRAM;
		end else if (addr == 16'hFFFF) begin
			dec.kind = LK_IENABLE;
		end

		// Invalid register holes are all outside the forwarded regions.
		if (addr == 16'hFF03 || addr inside {[16'hFF08:16'hFF0E]} ||
				addr inside {[16'hFF27:16'hFF2F]}) begin
			dec.hole = 1'b1;
		end
	end

endmodule

// ===== hdl/mmbd_store.sv =====
`timescale 1ns / 1ps

module mmbd_store #(
	parameter int WORK_RAM_DEPTH = 8192,
	parameter int HIGH_RAM_DEPTH = 127
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  logic                     cmd,
	input  logic [15:0]              addr,
	input  logic [7:0]               wdata,
	input  mmbd_pkg::local_kind_t    kind,
	output logic                     busy,
	output logic [7:0]               rd_byte
);
	import mmbd_pkg::*;

	localparam int WA = $clog2(WORK_RAM_DEPTH);
	localparam int HA = $clog2(HIGH_RAM_DEPTH);

	logic [7:0]    wram [WORK_RAM_DEPTH];
	logic [7:0]    hram [HIGH_RAM_DEPTH];
	logic [WA-1:0] clr_cnt_q;
	logic          clr_busy_q;
	logic [4:0]    irq_flag_q;
	logic [4:0]    irq_enable_q;
	logic [7:0]    boot_off_q;
	logic [7:0]    wram_rd_q;
	logic [7:0]    hram_rd_q;
	logic [7:0]    reg_rd_q;
	local_kind_t   kind_q;
	logic          wram_we;
	logic          hram_we;
	logic [WA-1:0] wram_wa;
	logic [HA-1:0] hram_wa;
	logic [7:0]    wram_wd;
	logic [7:0]    hram_wd;
	logic [7:0]    reg_rd;
	logic          hram_clr;

	assign busy = clr_busy_q;

	// Clearing sweep after reset: one work RAM entry per cycle, high RAM
	// alongside it while the count is inside the smaller memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == WA'(WORK_RAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign hram_clr = clr_busy_q && (clr_cnt_q < WA'(HIGH_RAM_DEPTH));

	// Write port selection: sweep zeros, or the accepted write.
	always_comb begin
		wram_we = clr_busy_q || (acc && cmd && kind == LK_WRAM);
		wram_wa = clr_busy_q ? clr_cnt_q : addr[WA-1:0];
		wram_wd = clr_busy_q ? 8'h00 : wdata;
		hram_we = hram_clr || (acc && cmd && kind == LK_HRAM);
		hram_wa = hram_clr ? clr_cnt_q[HA-1:0] : addr[HA-1:0];
		hram_wd = hram_clr ? 8'h00 : wdata;
	end

	// Work RAM, one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wram_we) begin
			wram[wram_wa] <= wram_wd;
		end
		if (acc) begin
			wram_rd_q <= wram[addr[WA-1:0]];
		end
	end

	// High RAM, same organization.
	always_ff @(posedge clk) begin
		if (hram_we) begin
			hram[hram_wa] <= hram_wd;
		end
		if (acc) begin
			hram_rd_q <= hram[addr[HA-1:0]];
		end
	end

	// Interrupt and boot registers are written on the accepting edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_flag_q   <= '0;
			irq_enable_q <= '0;
			boot_off_q   <= '0;
		end else if (acc && cmd) begin
			if (kind == LK_IFLAG) begin
				irq_flag_q <= wdata[4:0];
			end
			if (kind == LK_IENABLE) begin
				irq_enable_q <= wdata[4:0];
			end
			if (kind == LK_BOOT) begin
				boot_off_q <= wdata;
			end
		end
	end

	// Register read value, with the unwired interrupt bits as ones.
	always_comb begin
		case (kind)
			LK_IFLAG:   reg_rd = IRQ_PAD | {3'b000, irq_flag_q};
			LK_IENABLE: reg_rd = IRQ_PAD | {3'b000, irq_enable_q};
			LK_BOOT:    reg_rd = boot_off_q;
			default:    reg_rd = RD_UNMAPPED;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			reg_rd_q <= reg_rd;
			kind_q   <= kind;
		end
	end

	// Read byte of the item in the first stage.
	always_comb begin
		case (kind_q)
			LK_WRAM: rd_byte = wram_rd_q;
			LK_HRAM: rd_byte = hram_rd_q;
			default: rd_byte = reg_rd_q;
		endcase
	end

endmodule

// ===== hdl/memory_map_bus_decoder_unit.sv =====
`timescale 1ns / 1ps

// Bus decoder for a 16-bit memory map. Each accepted word is one read or
// write access; one result word follows per access, in order, through the
// first stage and the output register, and a new access can be taken every
// cycle while in_stall is low. Work RAM and high RAM are synchronous
// memories with one write and one registered read port, read and written
// on the accepting edge, so their registered read sets the depth of the
// pipeline, not the rate. After reset the block clears both memories in one
// pass, holding in_stall high until it ends.
module memory_map_bus_decoder_unit #(
	parameter int WORK_RAM_DEPTH = 8192,
	parameter int HIGH_RAM_DEPTH = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [15:0] addr,
	input  logic [7:0]  wdata,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  target,
	output logic        is_write,
	output logic [15:0] fwd_addr,
	output logic [7:0]  fwd_data,
	output logic [7:0]  rdata,
	output logic        invalid
);
	import mmbd_pkg::*;

	dec_t        dec;
	logic        acc;
	logic        adv;
	logic        busy;
	logic [7:0]  rd_byte;
	logic        valid_s1;
	logic        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wdata_s1;
	dec_t        dec_s1;
	logic        out_valid_q;
	logic [2:0]  target_q;
	logic        is_write_q;
	logic [15:0] fwd_addr_q;
	logic [7:0]  fwd_data_q;
	logic [7:0]  rdata_q;
	logic        invalid_q;

	mmbd_decode u_decode (
		.addr (addr),
		.dec  (dec)
	);

	mmbd_store #(
		.WORK_RAM_DEPTH (WORK_RAM_DEPTH),
		.HIGH_RAM_DEPTH (HIGH_RAM_DEPTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (acc),
		.cmd     (cmd),
		.addr    (addr),
		.wdata   (wdata),
		.kind    (dec.kind),
		.busy    (busy),
		.rd_byte (rd_byte)
	);

	// Handshake: the first stage moves on whenever the output register is
	// free or being emptied.
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = busy || (valid_s1 && !adv);
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// First stage holds the access while its memory read completes.
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= cmd;
			addr_s1  <= addr;
			wdata_s1 <= wdata;
			dec_s1   <= dec;
		end
	end

	// Output register: forwarded accesses carry the bus fields, local ones
	// the read byte and the invalid flag.
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			if (dec_s1.target != TGT_LOCAL) begin
				target_q   <= dec_s1.target;
				is_write_q <= cmd_s1;
				fwd_addr_q <= addr_s1;
				fwd_data_q <= cmd_s1 ? wdata_s1 : 8'h00;
				rdata_q    <= 8'h00;
				invalid_q  <= 1'b0;
			end else begin
				target_q   <= TGT_LOCAL;
				is_write_q <= 1'b0;
				fwd_addr_q <= 16'h0000;
				fwd_data_q <= 8'h00;
				rdata_q    <= cmd_s1 ? 8'h00 : rd_byte;
				invalid_q  <= dec_s1.hole;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign target    = target_q;
	assign is_write  = is_write_q;
	assign fwd_addr  = fwd_addr_q;
	assign fwd_data  = fwd_data_q;
	assign rdata     = rdata_q;
	assign invalid   = invalid_q;

endmodule

// ===== hdl/mmbd_checker.sv =====
`timescale 1ns / 1ps

module mmbd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  target,
	input logic        is_write,
	input logic [15:0] fwd_addr,
	input logic [7:0]  fwd_data,
	input logic [7:0]  rdata,
	input logic        invalid
);
	import mmbd_pkg::*;

	// A stalled result word stays and holds its target.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target) && $stable(rdata))
		else $error("stalled result word changed");

	// Forwarded accesses never carry local read data or the invalid flag.
	a_fwd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_LOCAL |-> rdata == 8'h00 && !invalid)
		else $error("forwarded word carries local fields");

	// Local accesses leave every forwarding field at zero.
	a_local_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_LOCAL |->
			!is_write && fwd_addr == 16'h0000 && fwd_data == 8'h00)
		else $error("local word carries forwarding fields");

	// A forwarded read passes no write byte.
	a_fwd_read: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target != TGT_LOCAL && !is_write |-> fwd_data == 8'h00)
		else $error("forwarded read carries a write byte");

endmodule

bind memory_map_bus_decoder_unit mmbd_checker u_mmbd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.target    (target),
	.is_write  (is_write),
	.fwd_addr  (fwd_addr),
	.fwd_data  (fwd_data),
	.rdata     (rdata),
	.invalid   (invalid)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

import mmbd_pkg::*;

// Bus direction carried by the cmd field.
localparam logic CMD_READ  = 1'b0;
localparam logic CMD_WRITE = 1'b1;

// One result word as the block presents it.
typedef struct packed {
	logic [2:0]  target;
	logic        is_write;
	logic [15:0] fwd_addr;
	logic [7:0]  fwd_data;
	logic [7:0]  rdata;
	logic        invalid;
} bus_result_t;

// Predicts the decode of each access and checks the result words in order.
class bus_scoreboard;
	logic [7:0]  work_ram [8192];
	logic [7:0]  high_ram [127];
	logic [4:0]  irq_flag;
	logic [4:0]  irq_enable;
	logic [7:0]  boot_off;
	bus_result_t expected_q [$];
	int          mismatches;

	function new();
		foreach (work_ram[i]) work_ram[i] = 8'h00;
		foreach (high_ram[i]) high_ram[i] = 8'h00;
		irq_flag   = '0;
		irq_enable = '0;
		boot_off   = '0;
		mismatches = 0;
	endfunction

	// Works out the result of one accepted access and applies its write, if any.
	function void note_access(logic wr, logic [15:0] a, logic [7:0] d);
		bus_result_t r;
		logic [7:0]  rd;
		r  = '0;
		rd = RD_UNMAPPED;

		// Regions that belong to an external unit.
		if (a <= 16'h7FFF)
			r.target = TGT_ROM;
		else if (a <= 16'h9FFF)
			r.target = TGT_VRAM;
		else if (a <= 16'hBFFF)
			r.target = TGT_CRAM;
		else if (a >= 16'hFE00 && a <= 16'hFE9F)
			r.target = TGT_OAM;
		else if (a == 16'hFF00)
			r.target = TGT_JOYPAD;
		else if (a >= 16'hFF04 && a <= 16'hFF07)
			r.target = TGT_TIMER;
		else if (a >= 16'hFF40 && a <= 16'hFF49)
			r.target = TGT_VIDEO;
		else
			r.target = TGT_LOCAL;

		if (r.target != TGT_LOCAL) begin
			r.is_write = wr;
			r.fwd_addr = a;
			r.fwd_data = (wr == CMD_WRITE) ? d : 8'h00;
		end else begin
			r.invalid = (a == 16'hFF03) || (a >= 16'hFF08 && a <= 16'hFF0E) ||
				(a >= 16'hFF27 && a <= 16'hFF2F);

			// Local storage; anything else here ignores writes and reads as all ones.
			if (a >= 16'hC000 && a <= 16'hDFFF) begin
				if (wr == CMD_WRITE)
					work_ram[13'(a - 16'hC000)] = d;
				else
					rd = work_ram[13'(a - 16'hC000)];
			end else if (a == 16'hFF0F) begin
				if (wr == CMD_WRITE)
					irq_flag = d[4:0];
				else
					rd = IRQ_PAD | {3'b000, irq_flag};
			end else if (a == 16'hFF50) begin
				if (wr == CMD_WRITE)
					boot_off = d;
				else
					rd = boot_off;
			end else if (a >= 16'hFF80 && a <= 16'hFFFE) begin
				if (wr == CMD_WRITE)
					high_ram[7'(a - 16'hFF80)] = d;
				else
					rd = high_ram[7'(a - 16'hFF80)];
			end else if (a == 16'hFFFF) begin
				if (wr == CMD_WRITE)
					irq_enable = d[4:0];
				else
					rd = IRQ_PAD | {3'b000, irq_enable};
			end
			r.rdata = (wr == CMD_WRITE) ? 8'h00 : rd;
		end
		expected_q.push_back(r);
	endfunction

	// Compares one accepted result word with the oldest prediction.
	function void check_result(bus_result_t got);
		bus_result_t want;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: result word with no access pending: ",
					"target=%0d is_write=%0b fwd_addr=%h ", got.target, got.is_write,
					got.fwd_addr, "fwd_data=%h rdata=%h invalid=%0b", got.fwd_data,
					got.rdata, got.invalid);
		end else begin
			want = expected_q.pop_front();
			if (got.target !== want.target || got.is_write !== want.is_write ||
					got.fwd_addr !== want.fwd_addr || got.fwd_data !== want.fwd_data ||
					got.rdata !== want.rdata || got.invalid !== want.invalid) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: expected target=%0d is_write=%0b fwd_addr=%h ",
						want.target, want.is_write, want.fwd_addr,
						"fwd_data=%h rdata=%h invalid=%0b\n", want.fwd_data,
						want.rdata, want.invalid,
						"       got      target=%0d is_write=%0b fwd_addr=%h ",
						got.target, got.is_write, got.fwd_addr,
						"fwd_data=%h rdata=%h invalid=%0b", got.fwd_data,
						got.rdata, got.invalid);
			end
		end
	endfunction
endclass

module testbench;
	// The idle limit covers the memory clearing pass after reset with room to spare.
	localparam int IDLE_LIMIT   = 40000;
	localparam int RANDOM_WORDS = 1450;
	localparam int LONG_HOLD    = 80;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        cmd       = CMD_READ;
	logic [15:0] addr      = '0;
	logic [7:0]  wdata     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  target;
	logic        is_write;
	logic [15:0] fwd_addr;
	logic [7:0]  fwd_data;
	logic [7:0]  rdata;
	logic        invalid;

	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	bus_scoreboard sb = new();

	memory_map_bus_decoder_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.addr      (addr),
		.wdata     (wdata),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.target    (target),
		.is_write  (is_write),
		.fwd_addr  (fwd_addr),
		.fwd_data  (fwd_data),
		.rdata     (rdata),
		.invalid   (invalid)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Offers one access word after a random gap (none in steady stretches) and returns once it is taken.
	task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= wr;
		addr     <= a;
		wdata    <= d;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_access(wr, a, d);
	endtask

	// Stimulus: directed corner accesses, then a random mix weighted toward local storage.
	initial begin
		int          pick;
		logic        wr;
		logic [15:0] a;
		logic [7:0]  d;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Region boundaries, interrupt padding, invalid holes and ignored writes.
		send_access(CMD_WRITE, 16'h0000, 8'hA5);
		send_access(CMD_READ,  16'h7FFF, 8'h5A);
		send_access(CMD_WRITE, 16'h9FFF, 8'h5A);
		send_access(CMD_READ,  16'hA000, 8'hFF);
		send_access(CMD_WRITE, 16'hBFFF, 8'hFF);
		send_access(CMD_WRITE, 16'hC000, 8'h3C);
		send_access(CMD_READ,  16'hC000, 8'h00);
		send_access(CMD_WRITE, 16'hDFFF, 8'hC3);
		send_access(CMD_READ,  16'hDFFF, 8'h00);
		send_access(CMD_WRITE, 16'hE000, 8'h77);
		send_access(CMD_READ,  16'hE000, 8'h00);
		send_access(CMD_READ,  16'hFE00, 8'h00);
		send_access(CMD_WRITE, 16'hFE9F, 8'h11);
		send_access(CMD_READ,  16'hFEA0, 8'h00);
		send_access(CMD_WRITE, 16'hFF00, 8'h30);
		send_access(CMD_READ,  16'hFF03, 8'h00);
		send_access(CMD_WRITE, 16'hFF07, 8'h04);
		send_access(CMD_WRITE, 16'hFF0E, 8'h99);
		send_access(CMD_WRITE, 16'hFF0F, 8'hFF);
		send_access(CMD_READ,  16'hFF0F, 8'h00);
		send_access(CMD_READ,  16'hFF2F, 8'h00);
		send_access(CMD_WRITE, 16'hFF49, 8'h80);
		send_access(CMD_WRITE, 16'hFF50, 8'h01);
		send_access(CMD_READ,  16'hFF50, 8'h00);
		send_access(CMD_WRITE, 16'hFFFE, 8'hEE);
		send_access(CMD_READ,  16'hFFFE, 8'h00);
		send_access(CMD_WRITE, 16'hFFFF, 8'hFF);
		send_access(CMD_READ,  16'hFFFF, 8'h00);

		// Random accesses; small RAM windows make reads hit earlier writes.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 64 == 0)
				tx_steady = ($urandom_range(0, 3) == 0);
			wr   = 1'($urandom_range(0, 1));
			d    = 8'($urandom_range(0, 255));
			pick = $urandom_range(0, 99);
			if (pick < 15)
				a = 16'($urandom_range(0, 16'hFFFF));
			else if (pick < 38)
				a = 16'(16'hC000 + (($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 8191) : $urandom_range(0, 15)));
			else if (pick < 56)
				a = 16'(16'hFF80 + $urandom_range(0, 126));
			else if (pick < 66) begin
				case ($urandom_range(0, 2))
					0: a = 16'hFF0F;
					1: a = 16'hFF50;
					default: a = 16'hFFFF;
				endcase
			end else if (pick < 80)
				a = 16'(16'hFF00 + $urandom_range(0, 127));
			else if (pick < 90)
				a = 16'(16'hFE00 + $urandom_range(0, 255));
			else begin
				// Addresses on either side of a region boundary.
				case ($urandom_range(0, 11))
					0: a = 16'h7FFF;
					1: a = 16'h8000;
					2: a = 16'hA000;
					3: a = 16'hBFFF;
					4: a = 16'hDFFF;
					5: a = 16'hE000;
					6: a = 16'hFDFF;
					7: a = 16'hFEA0;
					8: a = 16'hFEFF;
					9: a = 16'hFF4A;
					10: a = 16'hFF7F;
					default: a = 16'hFF3F;
				endcase
			end
			send_access(wr, a, d);
		end
		in_valid <= 1'b0;

		// Drain, then wait for any stray result word.
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("memory_map_bus_decoder_unit verification clean");
		else
			$display("memory_map_bus_decoder_unit verification failed");
		$finish;
	end

	// Result side: random stalls, quiet stretches and two long hold-offs.
	initial begin
		int hold;
		int taken;
		taken = 0;
		forever begin
			if (taken % 64 == 0)
				rx_steady = ($urandom_range(0, 3) == 0);
			hold = rx_steady ? 0 : $urandom_range(0, 7);
			if (taken == 400 || taken == 1000)
				hold = LONG_HOLD;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_result({target, is_write, fwd_addr, fwd_data, rdata, invalid});
			taken++;
		end
	end

	// Watchdog: ends the run when no word moves on either side for too long.
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				idle = 0;
			else
				idle++;
		end
		$display("memory_map_bus_decoder_unit verification failed");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/mmbd_pkg.sv
hdl/mmbd_decode.sv
hdl/mmbd_store.sv
hdl/memory_map_bus_decoder_unit.sv
hdl/mmbd_checker.sv
dv/testbench.sv
